@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Both expect clk in scope at the point of use; ASSERT_RST also expects arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while out of reset
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ sv/ppe_pkg.sv @@
`timescale 1ns / 1ps

package ppe_pkg;

	// Item modes
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_ADD  = 1'b1;

	// APB register map (word index taken from paddr[2])
	localparam int   APB_ADDR_W     = 3;
	localparam logic REG_DECAY_RATE = 1'b0;

	localparam logic [15:0] DECAY_RESET = 16'd256;

	// Lifetime is unsigned Q1.16, 1.0 when freshly added
	localparam logic [16:0] LIFE_FULL = 17'h10000;
	localparam logic [16:0] LIFE_DEAD = 17'h00000;

	localparam logic [8:0] LIVE_MAX = 9'd511;

	typedef struct packed {
		logic               mode;
		logic        [15:0] delta_time;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} in_item_t;

	typedef struct packed {
		logic [7:0] slot;
		logic       overwrote;
		logic [8:0] live_count;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic clear;      // clearing sweep: zero one lifetime entry
		logic load;       // input beat accepted, capture the item
		logic dec_mul;    // decay_rate * delta_time
		logic issue;      // read the pool at the sweep address, advance it
		logic scan_done;  // next-fit search resolved this cycle
		logic add_write;  // write the new particle
		logic finish;     // load the output register
	} ppe_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic addr_last;   // sweep address is the last slot
		logic issue_last;  // current issue is the last slot of the sweep
		logic issue_done;  // every slot has been read
		logic pipe_busy;   // tick pipeline still holds slots
		logic hit;         // search read returned a free slot
		logic miss;        // final search read returned a live slot
		logic out_free;    // output register can take a beat
	} ppe_stat_t;

endpackage

@@ sv/ppe_ctrl.sv @@
`timescale 1ns / 1ps

module ppe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_mode,
	output logic             in_stall,
	input  ppe_pkg::ppe_stat_t stat,
	output ppe_pkg::ppe_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_CLEAR      = 8'b0000_0001,
		S_IDLE       = 8'b0000_0010,
		S_TICK_DEC   = 8'b0000_0100,
		S_TICK_RUN   = 8'b0000_1000,
		S_TICK_DRAIN = 8'b0001_0000,
		S_ADD_SCAN   = 8'b0010_0000,
		S_ADD_WRITE  = 8'b0100_0000,
		S_FINISH     = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// State register; reset starts the lifetime clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.addr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (in_mode == ppe_pkg::MODE_ADD) ? S_ADD_SCAN : S_TICK_DEC;
				end
			end
			S_TICK_DEC: begin
				cmd.dec_mul = 1'b1;
				state_d     = S_TICK_RUN;
			end
			S_TICK_RUN: begin
				cmd.issue = 1'b1;
				if (stat.issue_last) begin
					state_d = S_TICK_DRAIN;
				end
			end
			S_TICK_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = S_FINISH;
				end
			end
			S_ADD_SCAN: begin
				if (stat.hit || stat.miss) begin
					cmd.scan_done = 1'b1;
					state_d       = S_ADD_WRITE;
				end else begin
					cmd.issue = !stat.issue_done;
				end
			end
			S_ADD_WRITE: begin
				cmd.add_write = 1'b1;
				state_d       = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

@@ sv/ppe_datapath.sv @@
`timescale 1ns / 1ps

module ppe_datapath #(
	parameter int MAX_PARTICLES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppe_pkg::in_item_t    in_data,
	input  logic [15:0]          decay_rate,
	input  ppe_pkg::ppe_cmd_t    cmd,
	output ppe_pkg::ppe_stat_t   stat,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ppe_pkg::out_item_t   out_data
);

	localparam int IW = $clog2(MAX_PARTICLES);
	localparam int KW = IW + 1;
	localparam int CW = $clog2(MAX_PARTICLES + 1);

	localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_PARTICLES - 1);
	localparam logic [KW-1:0] N_SLOTS   = KW'(MAX_PARTICLES);
	localparam logic [KW-1:0] N_LAST    = KW'(MAX_PARTICLES - 1);

	// Pool memories
	logic [16:0] life_mem [MAX_PARTICLES];
	logic [95:0] pos_mem  [MAX_PARTICLES];
	logic [95:0] vel_mem  [MAX_PARTICLES];

	// Item registers
	ppe_pkg::in_item_t item_q;
	logic              mode_q;
	logic [31:0]       mprod_q;
	logic [26:0]       dec_q;

	// Sweep and search state
	logic [IW-1:0] addr_q;
	logic [IW-1:0] addr_nx;
	logic [KW-1:0] cnt_q;
	logic [IW-1:0] next_q;
	logic [IW-1:0] slot_q;
	logic          full_q;
	logic [CW-1:0] live_q;

	// Stage 1: registered memory reads
	logic          valid_s1;
	logic          last_s1;
	logic [IW-1:0] addr_s1;
	logic [16:0]   life_s1;
	logic [95:0]   pos_s1;
	logic [95:0]   vel_s1;

	// Stage 2: products and new lifetime
	logic                valid_s2;
	logic                live_s2;
	logic                died_s2;
	logic [IW-1:0]       addr_s2;
	logic [16:0]         life_s2;
	logic [95:0]         pos_s2;
	logic signed [48:0]  prod_s2 [3];

	logic          wb_en;
	logic          life_we;
	logic [IW-1:0] life_wa;
	logic [16:0]   life_wd;
	logic          pos_we;
	logic [IW-1:0] pos_wa;
	logic [95:0]   pos_wd;
	logic [95:0]   pos_mv;
	logic [34:0]   dec_x5;
	logic          out_valid_q;
	ppe_pkg::out_item_t out_q;
	logic [IW+7:0] slot_ext;
	logic [CW+8:0] live_ext;

	// pos + floor(prod / 2^16), saturated to 32 bits
	function automatic logic [31:0] move_coord(logic [31:0] pos, logic signed [48:0] prod);
		logic signed [33:0] sum;
		sum = $signed({{2{pos[31]}}, pos}) + $signed({prod[48], prod[48:16]});
		if (sum[33:31] != 3'b000 && sum[33:31] != 3'b111) begin
			return sum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return sum[31:0];
	endfunction

	assign addr_nx = (addr_q == LAST_SLOT) ? '0 : addr_q + 1'b1;

	// Item capture and decay amount
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ppe_pkg::MODE_TICK;
		end else if (cmd.load) begin
			mode_q <= in_data.mode;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.dec_mul) begin
			mprod_q <= decay_rate * item_q.delta_time;
		end
		dec_q <= dec_x5[34:8];
	end

	// x5 by shift and add, then Q11.24 down to Q11.16
	assign dec_x5 = {mprod_q, 2'b00} + {3'b000, mprod_q};

	// Sweep address, read count, search result, live count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			cnt_q  <= '0;
			next_q <= '0;
			slot_q <= '0;
			full_q <= 1'b0;
			live_q <= '0;
		end else begin
			if (cmd.clear || cmd.issue) begin
				addr_q <= addr_nx;
			end else if (cmd.load) begin
				addr_q <= (in_data.mode == ppe_pkg::MODE_ADD) ? next_q : '0;
			end
			if (cmd.load) begin
				cnt_q  <= '0;
				slot_q <= '0;
				full_q <= 1'b0;
			end else if (cmd.issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.scan_done) begin
				slot_q <= stat.hit ? addr_s1 : '0;
				full_q <= !stat.hit;
			end
			if (cmd.add_write && !full_q) begin
				next_q <= slot_q;
				live_q <= live_q + 1'b1;
			end else if (wb_en && died_s2) begin
				live_q <= live_q - 1'b1;
			end
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1 && (mode_q == ppe_pkg::MODE_TICK);
		end
	end

	// Stage 1: read all three stores at the sweep address
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			life_s1 <= life_mem[addr_q];
			pos_s1  <= pos_mem[addr_q];
			vel_s1  <= vel_mem[addr_q];
			addr_s1 <= addr_q;
			last_s1 <= (cnt_q == N_LAST);
		end
	end

	// Stage 2: velocity * dt per axis, lifetime decay
	always_ff @(posedge clk) begin
		addr_s2 <= addr_s1;
		pos_s2  <= pos_s1;
		live_s2 <= (life_s1 != ppe_pkg::LIFE_DEAD);
		died_s2 <= (dec_q >= {10'd0, life_s1});
		life_s2 <= (dec_q >= {10'd0, life_s1}) ? ppe_pkg::LIFE_DEAD : life_s1 - dec_q[16:0];
		for (int k = 0; k < 3; k++) begin
			prod_s2[k] <= $signed(vel_s1[32*k +: 32]) * $signed({1'b0, item_q.delta_time});
		end
	end

	// Stage 3: add and saturate, write back live slots
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pos_mv[32*k +: 32] = move_coord(pos_s2[32*k +: 32], prod_s2[k]);
		end
	end

	assign wb_en = valid_s2 && live_s2;

	// Write port selection
	always_comb begin
		life_we = cmd.clear || cmd.add_write || wb_en;
		pos_we  = cmd.add_write || wb_en;
		if (cmd.clear) begin
			life_wa = addr_q;
			life_wd = ppe_pkg::LIFE_DEAD;
		end else if (cmd.add_write) begin
			life_wa = slot_q;
			life_wd = ppe_pkg::LIFE_FULL;
		end else begin
			life_wa = addr_s2;
			life_wd = life_s2;
		end
		if (cmd.add_write) begin
			pos_wa = slot_q;
			pos_wd = {item_q.pos_z, item_q.pos_y, item_q.pos_x};
		end else begin
			pos_wa = addr_s2;
			pos_wd = pos_mv;
		end
	end

	always_ff @(posedge clk) begin
		if (life_we) begin
			life_mem[life_wa] <= life_wd;
		end
		if (pos_we) begin
			pos_mem[pos_wa] <= pos_wd;
		end
		if (cmd.add_write) begin
			vel_mem[slot_q] <= {item_q.vel_z, item_q.vel_y, item_q.vel_x};
		end
	end

	// Output register
	assign slot_ext = {8'd0, slot_q};
	assign live_ext = {9'd0, live_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.slot       <= slot_ext[7:0];
			out_q.overwrote  <= full_q;
			out_q.live_count <= (live_ext > (CW + 9)'(ppe_pkg::LIVE_MAX)) ?
				ppe_pkg::LIVE_MAX : live_ext[8:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Status
	always_comb begin
		stat            = '0;
		stat.addr_last  = (addr_q == LAST_SLOT);
		stat.issue_last = (cnt_q == N_LAST);
		stat.issue_done = (cnt_q == N_SLOTS);
		stat.pipe_busy  = valid_s1 || valid_s2;
		stat.hit        = valid_s1 && (life_s1 == ppe_pkg::LIFE_DEAD);
		stat.miss       = valid_s1 && last_s1 && (life_s1 != ppe_pkg::LIFE_DEAD);
		stat.out_free   = !out_valid_q || !out_stall;
	end

endmodule

@@ sv/particle_pool_engine_top.sv @@
`timescale 1ns / 1ps
// Channel  Handshake                   Payload
// in       in_valid / in_stall         in_data  (ppe_pkg::in_item_t)
// out      out_valid / out_stall       out_data (ppe_pkg::out_item_t)
// cfg      APB psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// After reset the lifetime store is cleared, one slot a cycle, with in_stall high. A tick
// reads one pool slot per cycle through a three-stage update pipeline. An add reads
// one lifetime per cycle in a next-fit search that visits 1 to MAX_PARTICLES slots.
// A new item is taken while the last result waits on out_stall; a second finished
// result waits for the output register.

`include "assert_macros.svh"

module particle_pool_engine_top #(
	parameter int MAX_PARTICLES = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  ppe_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output ppe_pkg::out_item_t              out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ppe_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	ppe_pkg::ppe_cmd_t  cmd;
	ppe_pkg::ppe_stat_t stat;
	logic [15:0]        decay_q;
	logic               cfg_wr;

	// Decay rate register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == ppe_pkg::REG_DECAY_RATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= ppe_pkg::DECAY_RESET;
		end else if (cfg_wr) begin
			decay_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == ppe_pkg::REG_DECAY_RATE) ? {16'd0, decay_q} : '0;

	ppe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_mode  (in_data.mode),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ppe_datapath #(
		.MAX_PARTICLES (MAX_PARTICLES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (in_data),
		.decay_rate (decay_q),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	// Clear, issue and add_write commands never overlap
	`ASSERT_RST(a_wr_src_excl, $onehot0({cmd.clear, cmd.issue, cmd.add_write}), "pool write sources overlap")
	// An accepted beat takes the controller out of idle
	`ASSERT_RST(a_accept_busy, (in_valid && !in_stall) |=> in_stall, "accepted beat left controller idle")
	// Finishing an item always presents a result
	`ASSERT_RST(a_finish_out, cmd.finish |=> out_valid, "finished item produced no result beat")
	// Nothing is accepted while reset holds the clearing sweep
	`ASSERT_ALWAYS(a_reset_stall, !arst_n |-> in_stall, "input accepted during reset")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import ppe_pkg::*;

	localparam int POOL_SIZE = 256;
	localparam int RUN_LIMIT = 1500000;
	localparam int HOLD_CYCLES = 900;
	localparam int HOLD_AT_BEAT = 150;
	localparam logic [APB_ADDR_W-1:0] DECAY_ADDR = {REG_DECAY_RATE, 2'b00};
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	particle_pool_engine_top #(
		.MAX_PARTICLES(POOL_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Directed step: one item plus an optional hand-written result
	typedef struct {
		logic        mode;
		logic [15:0] dt;
		logic [31:0] p;
		logic [31:0] v;
		bit          typed;
		out_item_t   want;
	} step_row_t;

	// Shadow pool: only lifetimes and the search pointer reach the outputs
	logic [16:0] life_pool [POOL_SIZE];
	logic [7:0]  search_from;
	logic [15:0] decay_cfg;

	out_item_t owed_results [$];
	int fail_cnt;
	int mis_cnt;
	int n_add;
	int n_tick;
	int n_reuse;
	int peak_live;
	int cycles;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin : watchdog
		cycles = 0;
		while (cycles <= RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top failed");
		$finish;
	end

	// One pool step: next-fit add or a decaying tick
	function automatic out_item_t advance_pool(input in_item_t it);
		out_item_t r;
		logic [63:0] dec;
		int pick;
		int idx;
		int n;
		bit found;
		found = 1'b0;
		pick = 0;
		n = 0;
		if (it.mode == MODE_ADD) begin
			n_add++;
			// search from the remembered slot, wrapping through zero
			for (int i = 0; i < POOL_SIZE; i++) begin
				idx = (int'(search_from) + i) % POOL_SIZE;
				if (!found && life_pool[idx] == LIFE_DEAD) begin
					found = 1'b1;
					pick = idx;
				end
			end
			if (found)
				search_from = pick[7:0];
			else
				n_reuse++;
			life_pool[pick] = LIFE_FULL;
		end else begin
			n_tick++;
			dec = (64'(decay_cfg) * 64'(it.delta_time) * 64'd5) >> 8;
			for (int i = 0; i < POOL_SIZE; i++) begin
				if (life_pool[i] != LIFE_DEAD) begin
					if (dec >= 64'(life_pool[i]))
						life_pool[i] = LIFE_DEAD;
					else
						life_pool[i] = life_pool[i] - dec[16:0];
				end
			end
		end
		for (int i = 0; i < POOL_SIZE; i++)
			if (life_pool[i] != LIFE_DEAD)
				n++;
		if (n > peak_live)
			peak_live = n;
		r.slot = (it.mode == MODE_ADD) ? pick[7:0] : 8'd0;
		r.overwrote = (it.mode == MODE_ADD) && !found;
		r.live_count = (n > int'(LIVE_MAX)) ? LIVE_MAX : 9'(n);
		return r;
	endfunction

	function automatic step_row_t mk_row(input logic m, input logic [15:0] dt,
			input logic [31:0] p, input logic [31:0] v, input bit typed,
			input int slot, input int live);
		step_row_t r;
		r.mode = m;
		r.dt = dt;
		r.p = p;
		r.v = v;
		r.typed = typed;
		r.want.slot = slot[7:0];
		r.want.overwrote = 1'b0;
		r.want.live_count = live[8:0];
		return r;
	endfunction

	// Coordinates: mostly random, sometimes an extreme
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return Q_MAX;
			1: return Q_MIN;
			default: return $urandom();
		endcase
	endfunction

	function automatic in_item_t rand_item(input int add_pct);
		in_item_t it;
		it.mode = ($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_TICK;
		case ($urandom_range(0, 3))
			0: it.delta_time = 16'($urandom_range(0, 64));
			1: it.delta_time = 16'($urandom_range(0, 16383));
			2: it.delta_time = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
			default: it.delta_time = 16'($urandom());
		endcase
		it.pos_x = rand_coord();
		it.pos_y = rand_coord();
		it.pos_z = rand_coord();
		it.vel_x = rand_coord();
		it.vel_y = rand_coord();
		it.vel_z = rand_coord();
		return it;
	endfunction

	// Offer one beat, after a random gap if gaps is set; called and returns at a falling edge
	task automatic send_beat(input in_item_t it, input bit gaps, input bit typed,
			input out_item_t want);
		int gap;
		out_item_t r;
		gap = gaps ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		r = advance_pool(it);
		owed_results.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	// APB transfer on the decay register, ending with the bus idle
	task automatic apb_xfer(input bit wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= DECAY_ADDR;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Result side: random stalls, one long hold-off to back the block up
	initial begin : result_side
		int w;
		int got;
		bit rx_idle;
		out_item_t want;
		got = 0;
		mis_cnt = 0;
		rx_idle = 1'b1;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (got % 40 == 0)
				rx_idle = ($urandom_range(0, 2) != 0);
			if (got == HOLD_AT_BEAT)
				w = HOLD_CYCLES;
			else
				w = rx_idle ? $urandom_range(0, 16) : 0;
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			got++;
			if (owed_results.size() == 0) begin
				mis_cnt++;
				$display("%0t: unexpected result beat, actual %p", $time, out_data);
			end else begin
				want = owed_results.pop_front();
				if (out_data.slot !== want.slot) begin
					mis_cnt++;
					$display("%0t: slot expected %0d actual %0d",
						$time, want.slot, out_data.slot);
				end
				if (out_data.overwrote !== want.overwrote) begin
					mis_cnt++;
					$display("%0t: overwrote expected %0b actual %0b",
						$time, want.overwrote, out_data.overwrote);
				end
				if (out_data.live_count !== want.live_count) begin
					mis_cnt++;
					$display("%0t: live_count expected %0d actual %0d",
						$time, want.live_count, out_data.live_count);
				end
			end
		end
	end

	// Stimulus
	initial begin : stim
		step_row_t steps [$];
		in_item_t it;
		out_item_t none;
		logic [31:0] rd;
		logic [15:0] ph_decay [5];
		int ph_items [5];
		int ph_add [5];
		int pct;
		bit tx_idle;

		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_cnt = 0;
		n_add = 0;
		n_tick = 0;
		n_reuse = 0;
		peak_live = 0;
		none = '0;
		for (int i = 0; i < POOL_SIZE; i++)
			life_pool[i] = LIFE_DEAD;
		search_from = 8'd0;
		decay_cfg = DECAY_RESET;

		// reset, once
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		apb_xfer(1'b0, 32'd0, rd);
		if (rd[15:0] !== DECAY_RESET) begin
			fail_cnt++;
			$display("%0t: decay_rate after reset expected %0d actual %0d",
				$time, DECAY_RESET, rd[15:0]);
		end

		// directed: extremes, both modes, decay edge cases at rate 1.0
		steps = '{
			mk_row(MODE_TICK, 16'h0000, 32'd0, 32'd0, 1, 0, 0),
			mk_row(MODE_ADD, 16'h0000, Q_MAX, Q_MIN, 1, 0, 1),
			mk_row(MODE_ADD, 16'hFFFF, Q_MIN, Q_MAX, 1, 1, 2),
			mk_row(MODE_ADD, 16'h0000, 32'd0, 32'd0, 1, 2, 3),
			mk_row(MODE_ADD, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 3, 4),
			mk_row(MODE_TICK, 16'h0000, 32'd0, 32'd0, 1, 0, 4),
			mk_row(MODE_TICK, 16'h0001, 32'd0, 32'd0, 0, 0, 0),
			mk_row(MODE_TICK, 16'h8000, 32'd0, 32'd0, 1, 0, 0),
			mk_row(MODE_ADD, 16'h0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 0, 0, 0),
			mk_row(MODE_ADD, 16'h0000, 32'h0000_FFFF, 32'hFFFF_0000, 0, 0, 0),
			mk_row(MODE_TICK, 16'h3333, 32'd0, 32'd0, 0, 0, 0),
			mk_row(MODE_TICK, 16'h0001, 32'd0, 32'd0, 0, 0, 0),
			mk_row(MODE_ADD, 16'h1234, 32'h0001_0000, 32'hFFFF_8000, 0, 0, 0),
			mk_row(MODE_ADD, 16'h0000, Q_MAX, Q_MAX, 0, 0, 0),
			mk_row(MODE_ADD, 16'h0000, Q_MIN, Q_MIN, 0, 0, 0),
			mk_row(MODE_TICK, 16'h0033, 32'd0, 32'd0, 0, 0, 0),
			mk_row(MODE_TICK, 16'hFFFF, 32'd0, 32'd0, 1, 0, 0),
			mk_row(MODE_ADD, 16'h5555, 32'h7FFF_0000, 32'h0001_0000, 0, 0, 0),
			mk_row(MODE_TICK, 16'hAAAA, 32'd0, 32'd0, 0, 0, 0),
			mk_row(MODE_ADD, 16'h0000, 32'h8000_FFFF, 32'h7FFF_0001, 0, 0, 0),
			mk_row(MODE_TICK, 16'h0002, 32'd0, 32'd0, 0, 0, 0)
		};
		foreach (steps[i]) begin
			it.mode = steps[i].mode;
			it.delta_time = steps[i].dt;
			it.pos_x = steps[i].p;
			it.pos_y = ~steps[i].p;
			it.pos_z = steps[i].p ^ 32'h5555_5555;
			it.vel_x = steps[i].v;
			it.vel_y = ~steps[i].v;
			it.vel_z = steps[i].v ^ 32'hAAAA_AAAA;
			send_beat(it, 1'b1, steps[i].typed, steps[i].want);
		end
		in_valid <= 1'b0;

		// random phases; zero decay fills the pool so it overflows
		ph_decay = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 65534)), 16'd300};
		ph_items = '{340, 90, 90, 100, 60};
		ph_add = '{80, 55, 70, 65, 75};
		tx_idle = 1'b1;
		for (int p = 0; p < 5; p++) begin
			while (owed_results.size() != 0)
				@(posedge clk);
			repeat (4) @(negedge clk);
			apb_xfer(1'b1, {16'd0, ph_decay[p]}, rd);
			decay_cfg = ph_decay[p];
			apb_xfer(1'b0, 32'd0, rd);
			if (rd[15:0] !== ph_decay[p]) begin
				fail_cnt++;
				$display("%0t: decay_rate readback expected %0d actual %0d",
					$time, ph_decay[p], rd[15:0]);
			end
			for (int k = 0; k < ph_items[p]; k++) begin
				if (k % 40 == 0)
					tx_idle = ($urandom_range(0, 2) != 0);
				pct = (ph_decay[p] == 16'd0 && k < 270) ? 100 : ph_add[p];
				send_beat(rand_item(pct), tx_idle, 1'b0, none);
			end
			in_valid <= 1'b0;
		end

		// drain, then allow for one more full sweep
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (POOL_SIZE + 8) @(posedge clk);

		$display("Covered %0d beats: %0d adds, %0d ticks, %0d full-pool reuses of slot 0",
			n_add + n_tick, n_add, n_tick, n_reuse);
		$display("Peak live count %0d over six decay settings, %0d cycles",
			peak_live, cycles);
		if (fail_cnt == 0 && mis_cnt == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/ppe_pkg.sv
sv/ppe_ctrl.sv
sv/ppe_datapath.sv
sv/particle_pool_engine_top.sv
tb/tb_top.sv
